// ===== rtl/tcg_pkg.sv =====
`default_nettype none
package tcg_pkg;
  localparam logic [7:0] CODE_LF = 8'd10;
  localparam logic [7:0] CODE_CR = 8'd13;
  localparam int FONT_GLYPHS = 128;
  localparam logic [7:0] TOP_MARGIN = 8'd2;

  // one queued glyph job: cell origin and code
  typedef struct packed {
    logic [7:0] base_x;
    logic [7:0] base_y;
    logic [7:0] code;
  } job_t;

  function automatic logic [39:0] font_row(input logic [6:0] c);
    logic [39:0] f;
    begin
      unique case (c)
        7'd0: f = 40'h0000000000; 7'd1: f = 40'h3E0A34003E; 7'd2: f = 40'h183E003E22;
        7'd3: f = 40'h003E202000; 7'd4: f = 40'h221C00242A; 7'd5: f = 40'h0008383808;
        7'd6: f = 40'h1C2222221C; 7'd7: f = 40'h0038384482; 7'd8: f = 40'h1C3E626232;
        7'd9: f = 40'h2E26232322; 7'd10: f = 40'h0000000000; 7'd11: f = 40'h1C3E362236;
        7'd12: f = 40'h3E3E363636; 7'd13: f = 40'h0000000000; 7'd14: f = 40'h18081C2222;
        7'd15: f = 40'h63554D556B; 7'd16: f = 40'h003E0A0478; 7'd17: f = 40'h003E0A0478;
        7'd18: f = 40'h0038445F4E; 7'd19: f = 40'h003844445F; 7'd20: f = 40'h003C3C3C3C;
        7'd21: f = 40'h003E0A0478; 7'd22: f = 40'h1824422418; 7'd23: f = 40'h183C7E3C18;
        7'd24: f = 40'hC0F0FCF0C0; 7'd25: f = 40'h030F3F0F03; 7'd26: f = 40'hFF7E3C1800;
        7'd27: f = 40'h00183C7EFF; 7'd28: f = 40'h003C200000; 7'd29: f = 40'h0814001408;
        7'd30: f = 40'h080C0E0C08; 7'd31: f = 40'h0818381808; 7'd32: f = 40'h0000000000;
        7'd33: f = 40'h00005F0000; 7'd34: f = 40'h0007000700; 7'd35: f = 40'h147F147F14;
        7'd36: f = 40'h242A7F2A12; 7'd37: f = 40'h2313086462; 7'd38: f = 40'h3649552250;
        7'd39: f = 40'h0005030000; 7'd40: f = 40'h001C224100; 7'd41: f = 40'h0041221C00;
        7'd42: f = 40'h14083E0814; 7'd43: f = 40'h08083E0808; 7'd44: f = 40'h0050300000;
        7'd45: f = 40'h0808080808; 7'd46: f = 40'h0060600000; 7'd47: f = 40'h2010080402;
        7'd48: f = 40'h3E5149453E; 7'd49: f = 40'h00427F4000; 7'd50: f = 40'h4261514946;
        7'd51: f = 40'h2141454B31; 7'd52: f = 40'h1814127F10; 7'd53: f = 40'h2745454539;
        7'd54: f = 40'h3C4A494930; 7'd55: f = 40'h0171090503; 7'd56: f = 40'h3649494936;
        7'd57: f = 40'h064949291E; 7'd58: f = 40'h0036360000; 7'd59: f = 40'h0056360000;
        7'd60: f = 40'h0814224100; 7'd61: f = 40'h1414141414; 7'd62: f = 40'h0041221408;
        7'd63: f = 40'h0201510906; 7'd64: f = 40'h324979413E; 7'd65: f = 40'h7E1111117E;
        7'd66: f = 40'h7F49494936; 7'd67: f = 40'h3E41414122; 7'd68: f = 40'h7F4141221C;
        7'd69: f = 40'h7F49494941; 7'd70: f = 40'h7F09090901; 7'd71: f = 40'h3E4149497A;
        7'd72: f = 40'h7F0808087F; 7'd73: f = 40'h00417F4100; 7'd74: f = 40'h2040413F01;
        7'd75: f = 40'h7F08142241; 7'd76: f = 40'h7F40404040; 7'd77: f = 40'h7F020C027F;
        7'd78: f = 40'h7F0408107F; 7'd79: f = 40'h3E4141413E; 7'd80: f = 40'h7F09090906;
        7'd81: f = 40'h3E4151215E; 7'd82: f = 40'h7F09192946; 7'd83: f = 40'h4649494931;
        7'd84: f = 40'h01017F0101; 7'd85: f = 40'h3F4040403F; 7'd86: f = 40'h1F2040201F;
        7'd87: f = 40'h3F4038403F; 7'd88: f = 40'h6314081463; 7'd89: f = 40'h0708700807;
        7'd90: f = 40'h6151494543; 7'd91: f = 40'h007F414100; 7'd92: f = 40'h0204081020;
        7'd93: f = 40'h0041417F00; 7'd94: f = 40'h0402010204; 7'd95: f = 40'h4040404040;
        7'd96: f = 40'h0001020400; 7'd97: f = 40'h2054545478; 7'd98: f = 40'h7F48444438;
        7'd99: f = 40'h3844444420; 7'd100: f = 40'h384444487F; 7'd101: f = 40'h3854545418;
        7'd102: f = 40'h087E090102; 7'd103: f = 40'h0C5252523E; 7'd104: f = 40'h7F08040478;
        7'd105: f = 40'h00447D4000; 7'd106: f = 40'h2040443D00; 7'd107: f = 40'h7F10284400;
        7'd108: f = 40'h00417F4000; 7'd109: f = 40'h7C04180478; 7'd110: f = 40'h7C08040478;
        7'd111: f = 40'h3844444438; 7'd112: f = 40'h7C14141408; 7'd113: f = 40'h081414187C;
        7'd114: f = 40'h7C08040408; 7'd115: f = 40'h4854545420; 7'd116: f = 40'h043F444020;
        7'd117: f = 40'h3C4040207C; 7'd118: f = 40'h1C2040201C; 7'd119: f = 40'h3C4030403C;
        7'd120: f = 40'h4428102844; 7'd121: f = 40'h0C5050503C; 7'd122: f = 40'h4464544C44;
        7'd123: f = 40'h0000364100; 7'd124: f = 40'h00007F0000; 7'd125: f = 40'h0041360800;
        7'd126: f = 40'h1008081008; default: f = 40'h7846414678;
      endcase
      return f;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/text_cursor_glyph_renderer.sv =====
`default_nettype none
// Text cursor glyph renderer.
// in_char_code beats arrive on in_valid/in_stall. Line feed and carriage
// return only move the cursor; any other code draws a 6x8 cell at the cursor
// as 48 pixel beats on out_valid/out_stall, rows top to bottom, columns left
// to right, with out_last_pixel on the 48th beat.
// Pixels leave at one beat per cycle while a job is queued and out_stall is
// low. A code's job is first written to the job queue, then its first pixel
// to the pixel register if the back end is free. A two-entry job queue lets
// codes keep coming while a glyph is drawn; cursor-only codes never wait on
// pixels unless the queue is full.
// out_stall freezes the pixel register and the counter; the queue then fills
// and in_stall rises.
// Reset (rst_n low, synchronous) sets the cursor to column 0, line 0,
// empties the queue and restores the colors to 56 and 0.
// Colors are APB registers: 0x0 fore_color, 0x4 back_color.
module text_cursor_glyph_renderer #(
  parameter int CHARS_PER_LINE = 22,
  parameter int TEXT_LINES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] in_char_code,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_pixel_x,
  output logic [7:0] out_pixel_y,
  output logic [7:0] out_pixel_color,
  output logic out_last_pixel,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import tcg_pkg::*;
  localparam logic [2:0] ADDR_FORE = 3'd0;
  localparam logic [2:0] ADDR_BACK = 3'd4;
  logic [7:0] fore_r, back_r;
  job_t fjob, qjob;
  logic fvalid, fstall, qvalid, qtake;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= 8'd56;
      back_r <= 8'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_FORE) fore_r <= pwdata[7:0];
      if (paddr == ADDR_BACK) back_r <= pwdata[7:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FORE) prdata = {24'd0, fore_r};
    else if (paddr == ADDR_BACK) prdata = {24'd0, back_r};
  end

  tcg_front #(.CHARS_PER_LINE(CHARS_PER_LINE), .TEXT_LINES(TEXT_LINES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_code,
    .job(fjob), .job_valid(fvalid), .job_stall(fstall));
  tcg_queue u_queue (
    .clk, .rst_n, .wr_job(fjob), .wr_valid(fvalid), .wr_stall(fstall),
    .rd_job(qjob), .rd_valid(qvalid), .rd_take(qtake));
  tcg_back u_back (
    .clk, .rst_n, .job(qjob), .job_valid(qvalid), .job_take(qtake),
    .fore_color(fore_r), .back_color(back_r), .out_valid, .out_stall,
    .out_pixel_x, .out_pixel_y, .out_pixel_color, .out_last_pixel);
endmodule
`default_nettype wire

// ===== rtl/tcg_front.sv =====
`default_nettype none
module tcg_front #(
  parameter int CHARS_PER_LINE = 22,
  parameter int TEXT_LINES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] in_char_code,
  output tcg_pkg::job_t job,
  output logic job_valid,
  input  wire logic job_stall
);
  import tcg_pkg::*;
  logic [4:0] col_r, col_nxt;
  logic [3:0] line_r, line_nxt;
  logic [3:0] nline;
  logic [4:0] dcol;
  logic [3:0] dline;
  logic acc, is_lf, is_cr, wrap;

  assign in_stall = job_stall;
  assign acc = in_valid && !job_stall;
  assign is_lf = in_char_code == CODE_LF;
  assign is_cr = in_char_code == CODE_CR;
  assign nline = ({1'b0, line_r} + 5'd1 >= 5'(TEXT_LINES)) ? 4'd0 : line_r + 4'd1;
  assign wrap = col_r >= 5'(CHARS_PER_LINE);
  assign dcol = wrap ? 5'd0 : col_r;
  assign dline = wrap ? nline : line_r;
  assign job_valid = in_valid && !is_lf && !is_cr;
  assign job.code = in_char_code;
  assign job.base_x = 8'({dcol, 2'b00} + {1'b0, dcol, 1'b0});
  assign job.base_y = {1'b0, dline, 3'b000} + TOP_MARGIN;

  always_comb begin
    col_nxt = col_r;
    line_nxt = line_r;
    if (acc) begin
      priority if (is_lf) begin
        col_nxt = 5'd0;
        line_nxt = nline;
      end else if (is_cr) begin
        col_nxt = 5'd0;
      end else begin
        col_nxt = dcol + 5'd1;
        line_nxt = dline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      line_r <= '0;
    end else begin
      col_r <= col_nxt;
      line_r <= line_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tcg_queue.sv =====
`default_nettype none
module tcg_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tcg_pkg::job_t wr_job,
  input  wire logic wr_valid,
  output logic wr_stall,
  output tcg_pkg::job_t rd_job,
  output logic rd_valid,
  input  wire logic rd_take
);
  import tcg_pkg::*;
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_stall = cnt_r == 2'd2;
  assign wr = wr_valid && !wr_stall;
  assign rd_valid = cnt_r != 2'd0;
  assign rd = rd_take && rd_valid;
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
`ifndef SYNTHESIS
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count step");
`endif
endmodule
`default_nettype wire

// ===== rtl/tcg_back.sv =====
`default_nettype none
module tcg_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tcg_pkg::job_t job,
  input  wire logic job_valid,
  output logic job_take,
  input  wire logic [7:0] fore_color,
  input  wire logic [7:0] back_color,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_pixel_x,
  output logic [7:0] out_pixel_y,
  output logic [7:0] out_pixel_color,
  output logic out_last_pixel
);
  import tcg_pkg::*;
  logic [2:0] row_r, row_nxt;
  logic [2:0] i_r, i_nxt;
  logic [39:0] glyph;
  logic [5:0] bit_idx;
  logic on, last, adv;

  assign glyph = job.code[7] ? 40'd0 : font_row(job.code[6:0]);
  // font column 0 sits in the top byte
  assign bit_idx = {3'd4 - i_r, row_r};
  assign on = (i_r != 3'd5) && glyph[bit_idx];
  assign last = row_r == 3'd7 && i_r == 3'd5;
  assign adv = job_valid && (!out_valid || !out_stall);
  assign job_take = adv && last;

  always_comb begin
    i_nxt = i_r;
    row_nxt = row_r;
    if (adv) begin
      if (i_r == 3'd5) begin
        i_nxt = 3'd0;
        row_nxt = row_r + 3'd1;
      end else begin
        i_nxt = i_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      row_r <= '0;
      out_valid <= 1'b0;
    end else begin
      i_r <= i_nxt;
      row_r <= row_nxt;
      if (adv) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_x <= job.base_x + {5'd0, i_r};
      out_pixel_y <= job.base_y + {5'd0, row_r};
      out_pixel_color <= on ? fore_color : back_color;
      out_last_pixel <= last;
    end
  end
`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x)) else $error("beat dropped");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    i_r <= 3'd5) else $error("column index out of range");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> out_last_pixel && out_valid) else $error("job retired early");
`endif
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcg_pkg::*;

  localparam int LINE_CHARS = 22;
  localparam int LINE_COUNT = 16;
  localparam logic [2:0] ADDR_FORE = 3'd0;
  localparam logic [2:0] ADDR_BACK = 3'd4;

  // font columns, column 0 in the top byte, bit n of a column is glyph row n
  localparam logic [39:0] GLYPH_COLS [128] = '{
    40'h0000000000, 40'h3E0A34003E, 40'h183E003E22, 40'h003E202000,
    40'h221C00242A, 40'h0008383808, 40'h1C2222221C, 40'h0038384482,
    40'h1C3E626232, 40'h2E26232322, 40'h0000000000, 40'h1C3E362236,
    40'h3E3E363636, 40'h0000000000, 40'h18081C2222, 40'h63554D556B,
    40'h003E0A0478, 40'h003E0A0478, 40'h0038445F4E, 40'h003844445F,
    40'h003C3C3C3C, 40'h003E0A0478, 40'h1824422418, 40'h183C7E3C18,
    40'hC0F0FCF0C0, 40'h030F3F0F03, 40'hFF7E3C1800, 40'h00183C7EFF,
    40'h003C200000, 40'h0814001408, 40'h080C0E0C08, 40'h0818381808,
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0000364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] color;
    logic       last;
  } pixel_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [7:0] in_char_code;
  logic out_valid, out_stall;
  logic [7:0] out_pixel_x, out_pixel_y, out_pixel_color;
  logic out_last_pixel;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  text_cursor_glyph_renderer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color), .out_last_pixel(out_last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [7:0] char_q[$];
  pixel_t     pixel_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  bit beat_taken = 0;

  logic [4:0] cur_col;
  logic [3:0] cur_line;
  logic [7:0] fore, back;

  task automatic advance_line();
    cur_line = (cur_line >= LINE_COUNT - 1) ? 4'd0 : cur_line + 4'd1;
    cur_col = '0;
  endtask

  task automatic render_char(input logic [7:0] c);
    logic [7:0] bx, by, colbits;
    pixel_t p;
    if (c == CODE_LF) begin
      advance_line();
    end else if (c == CODE_CR) begin
      cur_col = '0;
    end else begin
      if (cur_col >= LINE_CHARS) advance_line();
      bx = 8'(6 * cur_col);
      by = 8'(8 * cur_line + 2);
      for (int r = 0; r < 8; r++) begin
        for (int i = 0; i < 6; i++) begin
          colbits = (c < FONT_GLYPHS && i < 5) ? GLYPH_COLS[c[6:0]][39 - 8 * i -: 8] : 8'h00;
          p.x = bx + 8'(i);
          p.y = by + 8'(r);
          p.color = colbits[r] ? fore : back;
          p.last = (r == 7 && i == 5);
          pixel_q.push_back(p);
        end
      end
      cur_col = cur_col + 5'd1;
    end
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // input side: a beat offered stays put until it is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      render_char(in_char_code);
      void'(char_q.pop_front());
      beat_taken <= 1;
    end else begin
      beat_taken <= 0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_char_code <= '0;
    end else if (!(in_valid && !beat_taken)) begin
      if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1;
        in_char_code <= char_q[0];
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_cnt < hold_len) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                 out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (e.x !== out_pixel_x || e.y !== out_pixel_y ||
            e.color !== out_pixel_color || e.last !== out_last_pixel) begin
          $display("%0t: pixel mismatch exp x=%0d y=%0d color=%h last=%b", $time,
                   e.x, e.y, e.color, e.last);
          $display("%0t:                act x=%0d y=%0d color=%h last=%b", $time,
                   out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_FORE) fore = val;
    else back = val;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (char_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    int k;
    k = $urandom_range(99);
    if (k < 65) return 8'($urandom_range(126, 32));
    if (k < 75) return CODE_LF;
    if (k < 80) return CODE_CR;
    if (k < 90) return 8'($urandom_range(255, 128));
    return 8'($urandom);
  endfunction

  task automatic load_random(input int n);
    int run;
    while (n > 0) begin
      // mostly long text runs so lines fill up and wrap past the last line
      if ($urandom_range(3) == 0) begin
        run = $urandom_range(30, 20);
        if (run > n) run = n;
        repeat (run) char_q.push_back(8'($urandom_range(126, 32)));
        n -= run;
      end else begin
        char_q.push_back(pick_code());
        n--;
      end
    end
  endtask

  initial begin
    logic [7:0] directed [18] = '{8'd0, 8'd127, 8'd128, 8'd255, 8'd65, CODE_CR, 8'd66,
                                  CODE_LF, 8'd1, 8'd24, 8'd26, 8'd200, CODE_LF, CODE_CR,
                                  8'd32, 8'd126, 8'd85, 8'd170};
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    out_stall = 0; in_valid = 0; in_char_code = '0;
    cur_col = '0; cur_line = '0; fore = 8'd56; back = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed beats with reset colors, no idling
    foreach (directed[i]) char_q.push_back(directed[i]);
    drain();

    write_reg(ADDR_FORE, 8'hFF);
    write_reg(ADDR_BACK, 8'h00);
    load_random(60);
    drain();

    write_reg(ADDR_FORE, 8'h00);
    write_reg(ADDR_BACK, 8'hFF);
    send_idle_pct = 87;
    load_random(60);
    drain();

    write_reg(ADDR_FORE, 8'($urandom));
    write_reg(ADDR_BACK, 8'($urandom));
    send_idle_pct = 0;
    stall_pct = 87;
    load_random(50);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_reg(ADDR_FORE, 8'hA5);
    write_reg(ADDR_BACK, 8'h5A);
    stall_pct = 0;
    hold_len = 400;
    load_random(60);
    drain();

    write_reg(ADDR_FORE, 8'($urandom));
    write_reg(ADDR_BACK, 8'($urandom));
    send_idle_pct = 20;
    stall_pct = 20;
    load_random(60);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
